// ===== rtl/radix_converter_assert.svh =====
// Assertion macros for the radix converter.
// Used by radix_converter.sv; expects clk and rst_n in scope.
`ifndef RADIX_CONVERTER_ASSERT_SVH
`define RADIX_CONVERTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radix_converter: same-cycle check failed");
`define RC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radix_converter: next-cycle check failed");
`else
`define RC_ASSERT_IMP(label, ante, cons)
`define RC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/rc_pkg.sv =====
// Shared constants and types for the radix converter.
// No dependencies; imported by radix_converter.sv.
package rc_pkg;

  localparam int MAX_DIGITS  = 32;
  localparam int VALUE_BITS  = 32;
  localparam int IN_VALUE_W  = 31;
  localparam int CHAR_W      = 8;
  localparam int BASE_W      = 6;
  localparam int DIGIT_W     = 6;
  localparam int OUT_VALUE_W = 32;
  localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W      = $clog2(MAX_DIGITS);
  localparam int STEP_W      = $clog2(IN_VALUE_W);
  localparam int PROD_W      = VALUE_BITS + BASE_W;
  localparam int IN_TDATA_W  = ((IN_VALUE_W + CHAR_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CHAR_W + OUT_VALUE_W + 7) / 8) * 8;

  localparam logic [BASE_W-1:0] BASE_MIN   = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(55);
  localparam logic [CHAR_W-1:0] CHAR_COLON = CHAR_W'(58);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = DIGIT_W'(10);

  localparam logic OP_TO_DIGITS = 1'b0;
  localparam logic OP_FEED      = 1'b1;

  typedef logic [BASE_W-1:0]     base_t;
  typedef logic [DIGIT_W-1:0]    digit_t;
  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [VALUE_BITS-1:0] acc_t;

endpackage

// ===== rtl/radix_converter.sv =====
// Radix converter top level: value to digit string and digit string to value.
// Depends on rc_pkg, rc_ram and radix_converter_assert.svh.
//
// Channels: in_* takes items, out_* returns result items, cfg_* writes the
// base (2 to 36; values outside are clamped). cfg_ready is always high and
// the base should be written only while the block is idle.
// A value item (tuser 0) is divided by the base one quotient bit per cycle
// on a shared restoring divider, one digit for each division. The
// remainders go to a 32-entry RAM, then are read back most significant
// first, one digit item at a time: the next is read only after the
// receiver takes the last. Worst case is base 2 with 31 digits.
// A digit item (tuser 1) goes through the multiplier, then the adder;
// with tlast set it then returns one value item with the overflow flag.
// in_tready is high only while idle. A stalled receiver holds the current
// result item and the block waits. Reset restores base 10 and clears the
// accumulator and the overflow flag; the remainder RAM is not cleared.
module radix_converter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rc_pkg::BASE_W-1:0]     cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rc_pkg::IN_TDATA_W-1:0] in_tdata,   // in_value, in_char, zero pad
  input  logic                          in_tuser,   // operation
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rc_pkg::OUT_TDATA_W-1:0] out_tdata, // out_char, out_value
  output logic                          out_tuser,  // out_overflow
  output logic                          out_tlast
);

  import rc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_MUL  = 3'd5;
  localparam logic [2:0] ST_ADD  = 3'd6;
  localparam logic [2:0] ST_VOUT = 3'd7;

  logic [2:0]            state_r, state_nxt;
  base_t                 base_r, base_eff;
  logic [IN_VALUE_W-1:0] v_r, v_nxt;
  digit_t                rem_r, rem_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [COUNT_W-1:0]    count_r, count_nxt;
  acc_t                  acc_r, acc_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  char_t                 char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic                  out_valid_r, out_valid_nxt;
  char_t                 out_char_r, out_char_nxt;
  logic [OUT_VALUE_W-1:0] out_value_r, out_value_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [DIGIT_W:0]      rem_sh;
  logic                  q_bit;
  digit_t                rem_step;
  logic [IN_VALUE_W-1:0] v_step;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  digit_t                ram_rdata;
  logic [CHAR_W-1:0]     mag;
  logic                  neg;
  acc_t                  prod_lo;
  logic [VALUE_BITS:0]   sum_pos;
  acc_t                  sum;
  logic                  ovf_add;
  logic                  ovf_mul;
  logic [COUNT_W-1:0]    count_inc;

  always_comb begin
    if (base_r < BASE_MIN) begin
      base_eff = BASE_MIN;
    end else if (base_r > BASE_MAX) begin
      base_eff = BASE_MAX;
    end else begin
      base_eff = base_r;
    end
  end

  assign rem_sh   = {rem_r, v_r[IN_VALUE_W-1]};
  assign q_bit    = rem_sh >= {1'b0, base_eff};
  assign rem_step = q_bit ? DIGIT_W'(rem_sh - {1'b0, base_eff}) : DIGIT_W'(rem_sh);
  assign v_step   = {v_r[IN_VALUE_W-2:0], q_bit};
  assign count_inc = count_r + COUNT_W'(1);

  assign ram_we    = (state_r == ST_DIV) && (step_r == STEP_W'(IN_VALUE_W - 1));
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_raddr = ADDR_W'(count_r - COUNT_W'(1));

  rc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_rem_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (rem_step),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (char_r < CHAR_COLON) begin
      if (char_r >= CHAR_ZERO) begin
        mag = char_r - CHAR_ZERO;
        neg = 1'b0;
      end else begin
        mag = CHAR_ZERO - char_r;
        neg = 1'b1;
      end
    end else begin
      mag = char_r - CHAR_ALPHA;
      neg = 1'b0;
    end
  end

  assign ovf_mul = |prod_r[PROD_W-1:VALUE_BITS];
  assign prod_lo = prod_r[VALUE_BITS-1:0];
  assign sum_pos = {1'b0, prod_lo} + (VALUE_BITS + 1)'(mag);

  always_comb begin
    if (neg) begin
      sum     = prod_lo - VALUE_BITS'(mag);
      ovf_add = prod_lo < VALUE_BITS'(mag);
    end else begin
      sum     = sum_pos[VALUE_BITS-1:0];
      ovf_add = sum_pos[VALUE_BITS];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    acc_nxt       = acc_r;
    ovf_nxt       = ovf_r;
    prod_nxt      = prod_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_value_nxt = out_value_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_TO_DIGITS) begin
            v_nxt     = in_tdata[IN_VALUE_W-1:0];
            rem_nxt   = '0;
            step_nxt  = '0;
            count_nxt = '0;
            state_nxt = ST_DIV;
          end else begin
            char_nxt  = in_tdata[IN_VALUE_W +: CHAR_W];
            last_nxt  = in_tlast;
            state_nxt = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        if (step_r == STEP_W'(IN_VALUE_W - 1)) begin
          count_nxt = count_inc;
          v_nxt     = v_step;
          rem_nxt   = '0;
          step_nxt  = '0;
          if (v_step == '0 || count_inc == COUNT_W'(MAX_DIGITS)) begin
            state_nxt = ST_RD;
          end
        end else begin
          v_nxt    = v_step;
          rem_nxt  = rem_step;
          step_nxt = step_r + STEP_W'(1);
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = (ram_rdata < DIGIT_TEN) ? CHAR_W'(ram_rdata) + CHAR_ZERO
                                                : CHAR_W'(ram_rdata) + CHAR_ALPHA;
        out_value_nxt = '0;
        out_ovf_nxt   = 1'b0;
        out_last_nxt  = count_r == COUNT_W'(1);
        state_nxt     = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          count_nxt     = count_r - COUNT_W'(1);
          state_nxt     = (count_r == COUNT_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      ST_MUL: begin
        prod_nxt  = {{BASE_W{1'b0}}, acc_r} * {{VALUE_BITS{1'b0}}, base_eff};
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (last_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_value_nxt = OUT_VALUE_W'(sum);
          out_ovf_nxt   = ovf_r | ovf_mul | ovf_add;
          out_last_nxt  = 1'b1;
          acc_nxt       = '0;
          ovf_nxt       = 1'b0;
          state_nxt     = ST_VOUT;
        end else begin
          acc_nxt   = sum;
          ovf_nxt   = ovf_r | ovf_mul | ovf_add;
          state_nxt = ST_IDLE;
        end
      end
      ST_VOUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= BASE_RESET;
      count_r     <= '0;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      if (cfg_valid) begin
        base_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    rem_r       <= rem_nxt;
    prod_r      <= prod_nxt;
    char_r      <= char_nxt;
    last_r      <= last_nxt;
    out_char_r  <= out_char_nxt;
    out_value_r <= out_value_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_value_r, out_char_r});
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

`include "radix_converter_assert.svh"

  `RC_ASSERT_IMP(a_no_accept_while_result, out_tvalid, !in_tready)
  `RC_ASSERT_IMP(a_rem_below_base, state_r == ST_DIV, rem_r < base_eff)
  `RC_ASSERT_IMP(a_count_in_range, 1'b1, count_r <= COUNT_W'(MAX_DIGITS))
  `RC_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready)

endmodule

// ===== rtl/rc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used by radix_converter.sv for the remainder store.
module rc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
